/* design/rau_pkg.sv */
// ----------------------------------------------------------------------------
// rau_pkg
// shared types and constants for the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int unsigned NUM_W = 33;
  localparam int unsigned DEN_W = 31;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_EVAL,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_DONE
  } state_t;

endpackage

/* design/rau_divider.sv */
// ----------------------------------------------------------------------------
// rau_divider
// restoring divider, one quotient bit per cycle, quotient and remainder
// ----------------------------------------------------------------------------
module rau_divider
  import rau_pkg::*;
#(
  parameter int unsigned W = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quo,
  output logic [W-1:0] rem
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  q_r, q_nxt;
  logic [W-1:0]  r_r, r_nxt;
  logic [W-1:0]  d_r, d_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    trial;
  logic [W:0]    diff;

  // one shift-subtract step
  always_comb begin
    trial    = {r_r, q_r[W-1]};
    diff     = trial - {1'b0, d_r};
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      r_nxt    = '0;
      d_nxt    = divisor;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[W]) begin
        r_nxt = diff[W-1:0];
        q_nxt = {q_r[W-2:0], 1'b1};
      end else begin
        r_nxt = trial[W-1:0];
        q_nxt = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    r_r   <= r_nxt;
    d_r   <= d_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quo  = q_r;
  assign rem  = r_r;

  // done pulses only at the end of a busy run
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without busy");
  a_no_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider busy and done together");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r) else $error("divider did not start");

endmodule

/* design/rational_arithmetic_unit_top.sv */
// operation: when the numerator or raw denominator is zero the divider is
//   skipped, else k euclid remainder steps and two reduction divisions run
//   on one shared bit-serial divider; add/sub take a third product
// throughput: one item at a time; in_stall high until the result transfer,
//   the next transfer is taken in the cycle after it at the earliest
// reset: synchronous active-low rst_n returns the sequencer to idle
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top
// fraction add/sub/mul/div with gcd reduction over one shared divider
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_top
  import rau_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_op,
  input  logic signed [OPERAND_WIDTH-1:0] in_a_num,
  input  logic signed [OPERAND_WIDTH-1:0] in_a_den,
  input  logic signed [OPERAND_WIDTH-1:0] in_b_num,
  input  logic signed [OPERAND_WIDTH-1:0] in_b_den,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [NUM_W-1:0]  out_res_num,
  output logic [DEN_W-1:0]         out_res_den,
  output logic                     out_zero_den_error
);

  localparam int unsigned PW = 2 * OPERAND_WIDTH;  // product width
  localparam int unsigned MW = PW + 1;             // magnitude width

  state_t state_r, state_nxt;

  logic [1:0] op_r;
  logic signed [OPERAND_WIDTH-1:0] an_r, ad_r, bn_r, bd_r;
  logic signed [PW-1:0] p1_r, p2_r, p3_r;
  logic signed [PW:0]   num_s;
  logic signed [PW-1:0] den_s;
  logic signed [PW:0]   den_x;
  logic [MW-1:0] num_mag, den_mag;
  logic [MW-1:0] un_r, ud_r, gy_r;
  logic          neg_r;
  logic          two_term;
  logic signed [NUM_W-1:0] rn_r;
  logic [DEN_W-1:0]        rd_r;
  logic                    err_r;
  logic                    dv_valid_r;
  logic [63:0]             q_wide;

  logic signed [OPERAND_WIDTH-1:0] mul_a, mul_b;
  logic signed [PW-1:0]            mul_p;

  logic          div_start;
  logic [MW-1:0] div_dnd, div_dsr, div_q, div_rem;
  logic          div_done;
  logic          in_fire, out_fire;

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;
  assign in_stall = (state_r != ST_IDLE) || dv_valid_r;
  assign two_term = (op_t'(op_r) == OP_ADD) || (op_t'(op_r) == OP_SUB);

  // single shared multiplier, operands picked by phase
  always_comb begin
    mul_a = ad_r;
    mul_b = bd_r;
    case (state_r)
      ST_MUL1: begin
        mul_a = an_r;
        mul_b = (op_t'(op_r) == OP_MUL) ? bn_r : bd_r;
      end
      ST_MUL2: begin
        mul_a = ad_r;
        mul_b = (op_t'(op_r) == OP_MUL) ? bd_r : bn_r;
      end
      default: ;  // third product: denominator of add/sub
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // combine products into raw numerator and denominator, then magnitudes
  always_comb begin
    den_s = p2_r;
    case (op_t'(op_r))
      OP_ADD: begin
        num_s = {p1_r[PW-1], p1_r} + {p2_r[PW-1], p2_r};
        den_s = p3_r;
      end
      OP_SUB: begin
        num_s = {p1_r[PW-1], p1_r} - {p2_r[PW-1], p2_r};
        den_s = p3_r;
      end
      default: num_s = {p1_r[PW-1], p1_r};
    endcase
    den_x   = {den_s[PW-1], den_s};
    num_mag = num_s[PW] ? MW'(-num_s) : MW'(num_s);
    den_mag = den_x[PW] ? MW'(-den_x) : MW'(den_x);
  end

  assign q_wide = 64'(div_q);

  rau_divider #(.W(MW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dnd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quo      (div_q),
    .rem      (div_rem)
  );

  // sequencer: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_MUL1;
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = two_term ? ST_MUL3 : ST_EVAL;
      ST_MUL3: state_nxt = ST_EVAL;
      ST_EVAL: state_nxt = (den_s == '0 || num_s == '0) ? ST_DONE : ST_GCD;
      ST_GCD:  if (div_done && div_rem == '0) state_nxt = ST_DIVN;
      ST_DIVN: if (div_done) state_nxt = ST_DIVD;
      ST_DIVD: if (div_done) state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer: divider control
  always_comb begin
    div_start = 1'b0;
    div_dnd   = gy_r;
    div_dsr   = div_rem;
    case (state_r)
      ST_EVAL: begin
        div_start = (den_s != '0) && (num_s != '0);
        div_dnd   = num_mag;
        div_dsr   = den_mag;
      end
      ST_GCD: begin
        div_start = div_done;
        if (div_rem == '0) begin
          div_dnd = un_r;
          div_dsr = gy_r;
        end
      end
      ST_DIVN: begin
        div_start = div_done;
        div_dnd   = ud_r;
        div_dsr   = gy_r;
      end
      default: ;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r <= in_op;
      an_r <= in_a_num;
      ad_r <= in_a_den;
      bn_r <= in_b_num;
      bd_r <= in_b_den;
    end
    case (state_r)
      ST_MUL1: p1_r <= mul_p;
      ST_MUL2: p2_r <= mul_p;
      ST_MUL3: p3_r <= mul_p;
      ST_EVAL: begin
        un_r  <= num_mag;
        ud_r  <= den_mag;
        gy_r  <= den_mag;
        neg_r <= (num_s[PW] != den_s[PW-1]) && (num_s != '0);
        err_r <= (den_s == '0);
        rn_r  <= '0;
        rd_r  <= (den_s == '0) ? '0 : DEN_W'(1);
      end
      ST_GCD:  if (div_done && div_rem != '0) gy_r <= div_rem;
      ST_DIVN: if (div_done) rn_r <= neg_r ? NUM_W'(-q_wide) : NUM_W'(q_wide);
      ST_DIVD: if (div_done) rd_r <= DEN_W'(q_wide);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      dv_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DONE) dv_valid_r <= 1'b1;
      else if (out_fire) dv_valid_r <= 1'b0;
    end
  end

  assign out_valid          = dv_valid_r;
  assign out_res_num        = rn_r;
  assign out_res_den        = rd_r;
  assign out_zero_den_error = err_r;

  a_idle_when_valid: assert property (@(posedge clk) disable iff (!rst_n)
    dv_valid_r |-> in_stall) else $error("input taken with result pending");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_valid_r && err_r) |-> (rn_r == '0 && rd_r == '0))
    else $error("error result not 0/0");
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_valid_r && !err_r) |-> rd_r != '0) else $error("zero denominator");

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// fraction unit bench: random and corner fractions pushed through the unit,
// each transfer's reduced result predicted exactly and checked in order
// ----------------------------------------------------------------------------
module tb
  import rau_pkg::*;
();

  localparam int unsigned OW = 16;
  localparam int NUM_ITEMS = 1850;

  typedef struct packed {
    op_t           op;
    logic [OW-1:0] a_num;
    logic [OW-1:0] a_den;
    logic [OW-1:0] b_num;
    logic [OW-1:0] b_den;
  } frac_req_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic             err;
  } frac_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_op = '0;
  logic signed [OW-1:0] in_a_num = '0, in_a_den = '0, in_b_num = '0, in_b_den = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [NUM_W-1:0] out_res_num;
  logic [DEN_W-1:0] out_res_den;
  logic out_zero_den_error;

  // stall as seen at the last rising edge
  logic in_stall_q = 1'b1;

  frac_req_t pending_reqs[$];
  frac_res_t expected_fracs[$];
  int mismatches = 0;
  bit all_sent = 1'b0;
  bit calm = 1'b0;

  rational_arithmetic_unit_top #(.OPERAND_WIDTH(OW)) dut (.*);

  always #5 clk = ~clk;

  // exact reduced fraction for one request
  function automatic frac_res_t reduce_fraction(frac_req_t r);
    longint an, ad, bn, bd, num, den, t;
    longint unsigned un, ud, x, y;
    frac_res_t res;
    an = longint'($signed(r.a_num));
    ad = longint'($signed(r.a_den));
    bn = longint'($signed(r.b_num));
    bd = longint'($signed(r.b_den));
    case (r.op)
      OP_ADD: begin num = an * bd + ad * bn; den = ad * bd; end
      OP_SUB: begin num = an * bd - ad * bn; den = ad * bd; end
      OP_MUL: begin num = an * bn; den = ad * bd; end
      default: begin num = an * bd; den = ad * bn; end
    endcase
    res = '0;
    if (den == 0) begin
      res.err = 1'b1;
      return res;
    end
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    x = un;
    y = ud;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    un = un / x;
    ud = ud / x;
    if (((num < 0) != (den < 0)) && num != 0) un = -un;
    res.num = un[NUM_W-1:0];
    res.den = ud[DEN_W-1:0];
    return res;
  endfunction

  function automatic logic [OW-1:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return OW'($signed($urandom_range(0, 8)) - 4);
      3: return OW'($urandom_range(0, 255));
      default: return OW'($urandom);
    endcase
  endfunction

  task automatic add_req(op_t op, logic [OW-1:0] an, logic [OW-1:0] ad,
                         logic [OW-1:0] bn, logic [OW-1:0] bd);
    pending_reqs.push_back('{op, an, ad, bn, bd});
  endtask

  // stimulus: directed corners, then random fractions
  initial begin
    op_t op;
    for (int k = 0; k < 4; k++) begin
      op = op_t'(k);
      add_req(op, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      add_req(op, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
      add_req(op, 16'h0000, 16'h0003, 16'h0000, 16'h0005);
      add_req(op, 16'h0005, 16'h0000, 16'h0003, 16'h0007);
      add_req(op, 16'hffff, 16'h0002, 16'h0001, 16'hfffe);
    end
    add_req(OP_DIV, 16'h0004, 16'h0003, 16'h0000, 16'h0005);
    add_req(OP_SUB, 16'h0001, 16'h0002, 16'h0001, 16'h0002);
    add_req(OP_MUL, 16'h0006, 16'h0004, 16'h0002, 16'h0009);
    for (int i = 0; i < NUM_ITEMS; i++)
      add_req(op_t'($urandom_range(0, 3)), rand_operand(), rand_operand(),
              rand_operand(), rand_operand());
  end

  // reset, then a calm window with no idling on either side
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2000) @(posedge clk);
    calm = 1'b1;
    repeat (20000) @(posedge clk);
    calm = 1'b0;
  end

  // driver: new transfer offered at the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall_q) begin
        pending_reqs.pop_front();
      end
      if ((!in_valid || !in_stall_q)) begin
        if (pending_reqs.size() > 0 && (calm || $urandom_range(0, 99) >= 29)) begin
          in_valid <= 1'b1;
          in_op <= pending_reqs[0].op;
          in_a_num <= pending_reqs[0].a_num;
          in_a_den <= pending_reqs[0].a_den;
          in_b_num <= pending_reqs[0].b_num;
          in_b_den <= pending_reqs[0].b_den;
        end else begin
          in_valid <= 1'b0;
          if (pending_reqs.size() == 0) all_sent = 1'b1;
        end
      end
      out_stall <= !calm && ($urandom_range(0, 99) < 29);
    end
  end

  // monitor: input acceptance feeds the predictor, results are checked
  always @(posedge clk) begin
    frac_res_t exp_r;
    in_stall_q <= in_stall;
    if (rst_n && in_valid && !in_stall)
      expected_fracs.push_back(reduce_fraction('{op_t'(in_op), in_a_num, in_a_den,
                                                 in_b_num, in_b_den}));
    if (rst_n && out_valid && !out_stall) begin
      if (expected_fracs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer");
      end else begin
        exp_r = expected_fracs.pop_front();
        if (out_res_num !== exp_r.num || out_res_den !== exp_r.den ||
            out_zero_den_error !== exp_r.err) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d/%0d err %0b, got %0d/%0d err %0b",
                     $signed(exp_r.num), exp_r.den, exp_r.err,
                     out_res_num, out_res_den, out_zero_den_error);
        end
      end
    end
  end

  // end of run
  initial begin
    wait (all_sent && !in_valid && expected_fracs.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_fracs.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // watchdog
  initial begin
    #200000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
